// File: src/assert_macros.svh
// Assertion macros used by the RTL of the controller router.
// Each macro uses the clk and rst_n found in the scope where it is expanded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)

`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/cllr_pkg.sv
// Types, codes and helper functions of the controller learn router.
// No dependencies; every other module file imports this package.
`timescale 1ns / 1ps

package cllr_pkg;

  localparam int NUM_PARAMS = 32;
  localparam int PARAM_W    = 5;
  localparam int CC_W       = 7;
  localparam int VAL_W      = 7;
  localparam int CC_DEPTH   = 128;
  localparam int LEVEL_W    = 16;
  localparam int ACT_W      = 3;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOG_MASK = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'h8000;
  localparam logic [VAL_W-1:0]   TOGGLE_MID = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_CC        = 3'd0,
    ACT_LEARN     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_CLEAR_ONE = 3'd3,
    ACT_CLEAR_ALL = 3'd4,
    ACT_QUERY     = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CC,
    OP_LEARN,
    OP_STOP,
    OP_CLEAR_ONE,
    OP_CLEAR_ALL,
    OP_QUERY
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_UPDATE  = 3'd1,
    KIND_LEARNED = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic [CC_W-1:0]    cc;
    logic [VAL_W-1:0]   val;
    logic [PARAM_W-1:0] param;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    kind_t              kind;
    logic [PARAM_W-1:0] param;
    logic [CC_W-1:0]    cc;
    logic               found;
    logic [LEVEL_W-1:0] level;
  } result_t;

  function automatic logic in_range(input logic [PARAM_W-1:0] p);
    return {1'b0, p} < (PARAM_W + 1)'(NUM_PARAMS);
  endfunction

  // floor((v*32768 + 63) / 127): 32768 = 127*258 + 2, so the quotient is
  // 258*v plus floor((2v + 63) / 127), which is 0, 1 or 2.
  function automatic logic [LEVEL_W-1:0] cc_level(input logic [VAL_W-1:0] v);
    logic [LEVEL_W-1:0] base;
    logic [VAL_W+1:0]   num;
    logic [1:0]         rnd;
    begin
      base = {1'b0, v, 8'd0} + {8'd0, v, 1'b0};
      num  = {1'b0, v, 1'b0} + (VAL_W + 2)'(63);
      if (num >= (VAL_W + 2)'(254)) begin
        rnd = 2'd2;
      end else if (num >= (VAL_W + 2)'(127)) begin
        rnd = 2'd1;
      end else begin
        rnd = 2'd0;
      end
      return base + {{(LEVEL_W-2){1'b0}}, rnd};
    end
  endfunction

endpackage

// File: src/cllr_front.sv
// Front end: takes input words and decodes them into queue operations.
// Depends on cllr_pkg.
`timescale 1ns / 1ps

module cllr_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cllr_pkg::ACT_W-1:0]   in_action,
  input  logic [cllr_pkg::CC_W-1:0]    in_cc_number,
  input  logic [cllr_pkg::VAL_W-1:0]   in_cc_value,
  input  logic [cllr_pkg::PARAM_W-1:0] in_param_index,
  input  logic                         enabled,
  input  logic [cllr_pkg::CFG_DATA_W-1:0] registered_mask,
  input  logic                         q_full,
  output cllr_pkg::push_t              q_push
);
  import cllr_pkg::*;

  op_t op;

  assign in_ready = !q_full;

  // Disabled or unknown actions still travel as a word: each gives one result.
  always_comb begin
    op = OP_NONE;
    if (enabled) begin
      case (in_action)
        ACT_CC:        op = OP_CC;
        ACT_LEARN:     op = (in_range(in_param_index) && registered_mask[in_param_index])
                            ? OP_LEARN : OP_NONE;
        ACT_STOP:      op = OP_STOP;
        ACT_CLEAR_ONE: op = OP_CLEAR_ONE;
        ACT_CLEAR_ALL: op = OP_CLEAR_ALL;
        ACT_QUERY:     op = OP_QUERY;
        default:       op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    q_push.push       = in_valid && !q_full;
    q_push.item.op    = op;
    q_push.item.cc    = in_cc_number;
    q_push.item.val   = in_cc_value;
    q_push.item.param = in_param_index;
  end

endmodule

// File: src/cllr_fifo.sv
// Short queue of decoded words between the front end and the back end.
// Depends on cllr_pkg.
`timescale 1ns / 1ps

module cllr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  cllr_pkg::push_t q_push,
  output logic            q_full,
  input  logic            q_pop,
  output logic            q_valid,
  output cllr_pkg::item_t q_item
);
  import cllr_pkg::*;

  item_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  count_r;
  logic [Q_PTR_W-1:0]  wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_nxt;
  logic                do_push;
  logic                do_pop;

  assign q_full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_push.item;
    end
  end

endmodule

// File: src/cllr_back.sv
// Back end: holds both mapping tables and the learn state, executes one word
// at a time and drives the result register. Depends on cllr_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cllr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cllr_pkg::item_t               q_item,
  output logic                          q_pop,
  input  logic [cllr_pkg::CFG_DATA_W-1:0] registered_mask,
  input  logic [cllr_pkg::CFG_DATA_W-1:0] toggle_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cllr_pkg::result_t             out_res
);
  import cllr_pkg::*;

  bk_state_t state_r;
  bk_state_t state_nxt;
  item_t     item_r;

  // Controller table: valid bits in flops, parameter numbers in a memory.
  logic [CC_DEPTH-1:0] cc_valid_r;
  logic [CC_DEPTH-1:0] cc_valid_nxt;
  logic [PARAM_W-1:0]  cc_param_mem [CC_DEPTH];
  logic [PARAM_W-1:0]  cc_param_rd_r;
  logic                cc_mem_we;

  // Parameter table.
  logic [NUM_PARAMS-1:0] pm_valid_r;
  logic [NUM_PARAMS-1:0] pm_valid_nxt;
  logic [CC_W-1:0]       pm_cc_r [NUM_PARAMS];
  logic [PARAM_W-1:0]    pm_raddr;
  logic [CC_W-1:0]       pm_rd;
  logic                  pm_we;

  logic               learn_active_r;
  logic               learn_active_nxt;
  logic [PARAM_W-1:0] learn_target_r;
  logic [PARAM_W-1:0] learn_target_nxt;

  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    out_free;
  logic    exec;
  logic    cc_hit;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    exec  = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = q_valid;
      BK_EXEC: exec  = out_free;
      default: begin
        q_pop = 1'b0;
        exec  = 1'b0;
      end
    endcase
  end

  // One read port on the parameter table: a controller word reads the learn target,
  // everything else reads the word's parameter.
  assign pm_raddr = (item_r.op == OP_CC) ? learn_target_r : item_r.param;
  assign pm_rd    = pm_cc_r[pm_raddr];
  assign cc_hit   = cc_valid_r[item_r.cc];

  always_comb begin
    res              = '0;
    cc_valid_nxt     = cc_valid_r;
    pm_valid_nxt     = pm_valid_r;
    learn_active_nxt = learn_active_r;
    learn_target_nxt = learn_target_r;
    cc_mem_we        = 1'b0;
    pm_we            = 1'b0;
    case (item_r.op)
      OP_CC: begin
        if (learn_active_r) begin
          if (in_range(learn_target_r)) begin
            // Drop both old bindings, then bind.
            if (cc_hit && in_range(cc_param_rd_r)) begin
              pm_valid_nxt[cc_param_rd_r] = 1'b0;
            end
            if (pm_valid_r[learn_target_r]) begin
              cc_valid_nxt[pm_rd] = 1'b0;
            end
            cc_valid_nxt[item_r.cc]      = 1'b1;
            pm_valid_nxt[learn_target_r] = 1'b1;
            cc_mem_we = 1'b1;
            pm_we     = 1'b1;
            res.kind  = KIND_LEARNED;
            res.param = learn_target_r;
            res.cc    = item_r.cc;
          end
          learn_active_nxt = 1'b0;
          learn_target_nxt = '0;
        end else if (cc_hit && in_range(cc_param_rd_r) && registered_mask[cc_param_rd_r]) begin
          res.kind  = KIND_UPDATE;
          res.param = cc_param_rd_r;
          res.cc    = item_r.cc;
          if (toggle_mask[cc_param_rd_r]) begin
            res.level = (item_r.val > TOGGLE_MID) ? LEVEL_FULL : '0;
          end else begin
            res.level = cc_level(item_r.val);
          end
        end
      end
      OP_LEARN: begin
        learn_active_nxt = 1'b1;
        learn_target_nxt = item_r.param;
        res.kind         = KIND_DONE;
      end
      OP_STOP: begin
        learn_active_nxt = 1'b0;
        learn_target_nxt = '0;
        res.kind         = KIND_DONE;
      end
      OP_CLEAR_ONE: begin
        if (in_range(item_r.param) && pm_valid_r[item_r.param]) begin
          cc_valid_nxt[pm_rd]        = 1'b0;
          pm_valid_nxt[item_r.param] = 1'b0;
        end
        res.kind = KIND_DONE;
      end
      OP_CLEAR_ALL: begin
        cc_valid_nxt = '0;
        pm_valid_nxt = '0;
        res.kind     = KIND_DONE;
      end
      OP_QUERY: begin
        res.kind  = KIND_QUERY;
        res.param = item_r.param;
        if (in_range(item_r.param) && pm_valid_r[item_r.param]) begin
          res.found = 1'b1;
          res.cc    = pm_rd;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= BK_IDLE;
      cc_valid_r     <= '0;
      pm_valid_r     <= '0;
      learn_active_r <= 1'b0;
      learn_target_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        cc_valid_r     <= cc_valid_nxt;
        pm_valid_r     <= pm_valid_nxt;
        learn_active_r <= learn_active_nxt;
        learn_target_r <= learn_target_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r        <= q_item;
      cc_param_rd_r <= cc_param_mem[q_item.cc];
    end
    if (exec && cc_mem_we) begin
      cc_param_mem[item_r.cc] <= learn_target_r;
    end
    if (exec && pm_we) begin
      pm_cc_r[learn_target_r] <= item_r.cc;
    end
    if (exec) begin
      out_res_r <= res;
    end
  end

  `ASSERT_ALWAYS(a_map_is_bijection, $countones(cc_valid_r) == $countones(pm_valid_r), "controller and parameter tables disagree on mapping count")
  `ASSERT_IMPLIES(a_result_from_exec, $rose(out_valid_r), $past(state_r == BK_EXEC), "result appeared without an execute cycle")
  `ASSERT_NEXT(a_bind_ends_learn, exec && item_r.op == OP_CC && learn_active_r, !learn_active_r && cc_valid_r[$past(item_r.cc)], "bind did not end learning or set the controller entry")

endmodule

// File: src/midi_cc_learn_router.sv
// Top level of the controller learn router: configuration registers, front
// end, word queue and back end. Depends on cllr_pkg, cllr_front, cllr_fifo, cllr_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    action, cc_number, cc_value, param_index
//   out_     output     out_valid/out_ready  kind, target_param, bound_cc, found, level
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Each word passes through the back end's states in order: IDLE pops it and reads the
// controller table memory at the word's controller number; EXEC, once the result
// register is free, executes it and loads that register. The back end handles one
// word at a time and takes no new word until it is through with the last. A two-word
// queue lets the input keep accepting while the result register waits on out_ready.
// Reset is synchronous and clears both tables through their valid bits at once.
`timescale 1ns / 1ps

module midi_cc_learn_router (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cllr_pkg::ACT_W-1:0]      in_action,
  input  logic [cllr_pkg::CC_W-1:0]       in_cc_number,
  input  logic [cllr_pkg::VAL_W-1:0]      in_cc_value,
  input  logic [cllr_pkg::PARAM_W-1:0]    in_param_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cllr_pkg::KIND_W-1:0]     out_kind,
  output logic [cllr_pkg::PARAM_W-1:0]    out_target_param,
  output logic [cllr_pkg::CC_W-1:0]       out_bound_cc,
  output logic                            out_found,
  output logic [cllr_pkg::LEVEL_W-1:0]    out_level,
  input  logic                            cfg_we,
  input  logic [cllr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cllr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cllr_pkg::*;

  logic                  enabled_r;
  logic [CFG_DATA_W-1:0] reg_mask_r;
  logic [CFG_DATA_W-1:0] tog_mask_r;

  push_t   q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  item_t   q_item;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      reg_mask_r <= '0;
      tog_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:  enabled_r  <= cfg_wdata[0];
        CFG_REG_MASK: reg_mask_r <= cfg_wdata;
        CFG_TOG_MASK: tog_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cllr_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_cc_number    (in_cc_number),
    .in_cc_value     (in_cc_value),
    .in_param_index  (in_param_index),
    .enabled         (enabled_r),
    .registered_mask (reg_mask_r),
    .q_full          (q_full),
    .q_push          (q_push)
  );

  cllr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  cllr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .registered_mask (reg_mask_r),
    .toggle_mask     (tog_mask_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_res         (res)
  );

  assign out_kind         = res.kind;
  assign out_target_param = res.param;
  assign out_bound_cc     = res.cc;
  assign out_found        = res.found;
  assign out_level        = res.level;

endmodule
